>>> hw/rtl/kscip_pkg.sv
// ---------------------------------------------------------------------------
// kscip_pkg: shared types and constants of the keyword substitution cipher
// Alphabet size, request codes and the classified item between front and back.
// ---------------------------------------------------------------------------
package kscip_pkg;

    // alphabet: ALPHABET_SIZE consecutive codes from 'A'
    localparam int ALPHABET_SIZE = 26;
    localparam int IDX_W         = $clog2(ALPHABET_SIZE);
    localparam int LEN_W         = $clog2(ALPHABET_SIZE + 1);

    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LZ  = 8'h7A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_KEY   = 2'd1;
    localparam logic [1:0] REQ_MSG   = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // decoupling queue between front and back
    localparam int QA_W    = 1;
    localparam int Q_DEPTH = 2 ** QA_W;

    // classified beat handed from front to back
    typedef struct packed {
        logic [1:0]       req;
        logic             letter;
        logic             blank;
        logic [IDX_W-1:0] idx;
    } t_item;

endpackage

>>> hw/rtl/kscip_front.sv
// ---------------------------------------------------------------------------
// kscip_front: input side of the cipher
// Takes request beats, folds case, classifies the character and queues it.
// ---------------------------------------------------------------------------
module kscip_front (
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_char_in,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output kscip_pkg::t_item     o_q_item
);

    logic [7:0] w_fold;
    logic [7:0] w_diff;

    // fold lower case onto upper case
    always_comb begin
        if (i_char_in >= kscip_pkg::CHAR_LA && i_char_in <= kscip_pkg::CHAR_LZ) begin
            w_fold = i_char_in - kscip_pkg::CASE_GAP;
        end else begin
            w_fold = i_char_in;
        end
    end

    assign w_diff = w_fold - kscip_pkg::CHAR_A;

    // classify
    always_comb begin
        o_q_item.req    = i_req_type;
        o_q_item.letter = (w_fold >= kscip_pkg::CHAR_A)
                          && (w_diff < 8'(kscip_pkg::ALPHABET_SIZE));
        o_q_item.blank  = (w_fold == kscip_pkg::CHAR_SP)
                          || (w_fold >= kscip_pkg::CHAR_TAB && w_fold <= kscip_pkg::CHAR_CR);
        o_q_item.idx    = w_diff[kscip_pkg::IDX_W-1:0];
    end

    // unused request code is accepted and dropped here
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full && (i_req_type != kscip_pkg::REQ_NOP);

endmodule

>>> hw/rtl/kscip_fifo.sv
// ---------------------------------------------------------------------------
// kscip_fifo: short queue between front and back
// Register-based, Q_DEPTH entries, first in first out.
// ---------------------------------------------------------------------------
module kscip_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  kscip_pkg::t_item     i_item,
    output logic                 o_full,
    output logic                 o_vld,
    output kscip_pkg::t_item     o_item,
    input  logic                 i_pop
);

    kscip_pkg::t_item               r_mem [kscip_pkg::Q_DEPTH];
    logic [kscip_pkg::QA_W-1:0]     r_wr;
    logic [kscip_pkg::QA_W-1:0]     r_rd;
    logic [kscip_pkg::QA_W:0]       r_cnt;
    logic                           w_wr_en;
    logic                           w_rd_en;

    assign o_full  = (r_cnt == (kscip_pkg::QA_W+1)'(kscip_pkg::Q_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && o_vld;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) r_wr <= r_wr + 1'b1;
            if (w_rd_en) r_rd <= r_rd + 1'b1;
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr_en && w_rd_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_wr] <= i_item;
    end

endmodule

>>> hw/rtl/kscip_back.sv
// ---------------------------------------------------------------------------
// kscip_back: execution side of the cipher
// Holds the key state and cipher table, runs the table fill and substitutes.
// ---------------------------------------------------------------------------
module kscip_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_vld,
    input  kscip_pkg::t_item     i_q_item,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [7:0]           o_cipher_char
);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_FILL = 1'b1;

    localparam int N = kscip_pkg::ALPHABET_SIZE;
    localparam int W = kscip_pkg::IDX_W;
    localparam int L = kscip_pkg::LEN_W;

    logic [W-1:0]   r_table [N];
    logic [N-1:0]   r_used;
    logic [L-1:0]   r_key_len;
    logic           r_done;
    logic           r_state;
    logic [L-1:0]   r_fill_l;
    logic [L-1:0]   r_slot;
    logic           r_out_vld;
    logic [7:0]     r_out_char;

    logic           w_out_free;
    logic           w_is_msg;
    logic           w_take;
    logic           w_key_wr;
    logic           w_fill_end;
    logic           w_fill_wr;
    logic           w_emit;

    assign w_out_free = !r_out_vld || i_pop;
    assign w_is_msg   = (i_q_item.req == kscip_pkg::REQ_MSG);

    // head beat retires when its work is possible this cycle
    assign w_take = i_q_vld && (r_state == ST_RUN)
                    && (!w_is_msg || (r_done && (i_q_item.blank || w_out_free)));
    assign o_q_pop = w_take;
    assign w_emit  = w_take && w_is_msg && !i_q_item.blank;

    // new keyword letter goes to the next slot
    assign w_key_wr = w_take && (i_q_item.req == kscip_pkg::REQ_KEY) && !r_done
                      && i_q_item.letter && !r_used[i_q_item.idx]
                      && (r_key_len < L'(N));

    // fill pass: one letter a cycle, ascending
    assign w_fill_end = (r_fill_l == L'(N)) || (r_slot == L'(N));
    assign w_fill_wr  = (r_state == ST_FILL) && !w_fill_end && !r_used[r_fill_l[W-1:0]];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_key_len <= '0;
            r_done    <= 1'b0;
            r_state   <= ST_RUN;
            r_fill_l  <= '0;
            r_slot    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (i_q_vld && w_is_msg && !r_done) begin
                        r_state  <= ST_FILL;
                        r_fill_l <= '0;
                        r_slot   <= r_key_len;
                    end
                    if (w_take && (i_q_item.req == kscip_pkg::REQ_CLEAR)) begin
                        r_used    <= '0;
                        r_key_len <= '0;
                        r_done    <= 1'b0;
                    end
                    if (w_key_wr) begin
                        r_used[i_q_item.idx] <= 1'b1;
                        r_key_len            <= r_key_len + 1'b1;
                    end
                end
                ST_FILL: begin
                    if (w_fill_end) begin
                        r_done  <= 1'b1;
                        r_state <= ST_RUN;
                    end else begin
                        r_fill_l <= r_fill_l + 1'b1;
                        if (w_fill_wr) r_slot <= r_slot + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase

            // result register
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // cipher table, written by keyword load and by the fill pass
    always_ff @(posedge i_clk) begin
        if (w_key_wr) begin
            r_table[r_key_len[W-1:0]] <= i_q_item.idx;
        end else if (w_fill_wr) begin
            r_table[r_slot[W-1:0]] <= r_fill_l[W-1:0];
        end
    end

    // substitution result
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (i_q_item.letter) begin
                r_out_char <= kscip_pkg::CHAR_A + 8'(r_table[i_q_item.idx]);
            end else begin
                r_out_char <= 8'h00;
            end
        end
    end

    assign o_empty       = !r_out_vld;
    assign o_cipher_char = r_out_char;

endmodule

>>> hw/rtl/keyword_substitution_cipher.sv
// ---------------------------------------------------------------------------
// keyword_substitution_cipher: mixed-alphabet substitution encryptor
// Keyword beats build the cipher alphabet; message beats are substituted.
// ---------------------------------------------------------------------------
// Push clear, keyword and message beats; pop one cipher letter per message
// character that is not whitespace (0 for a non-letter). Message beats
// sustain one per cycle while the reader keeps popping. The first
// message beat after reset or a clear waits while the back unit fills
// the rest of the table, one alphabet letter per cycle. A two-entry
// queue parts the classifying front from the back unit, and a result
// register parts the back unit from the reader.
module keyword_substitution_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_in,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_cipher_char
);

    kscip_pkg::t_item   w_f_item;
    kscip_pkg::t_item   w_b_item;
    logic               w_f_push;
    logic               w_q_full;
    logic               w_q_vld;
    logic               w_q_pop;

    kscip_front u_front (
        .i_push     (push),
        .o_full     (full),
        .i_req_type (i_req_type),
        .i_char_in  (i_char_in),
        .i_q_full   (w_q_full),
        .o_q_push   (w_f_push),
        .o_q_item   (w_f_item)
    );

    kscip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_item  (w_f_item),
        .o_full  (w_q_full),
        .o_vld   (w_q_vld),
        .o_item  (w_b_item),
        .i_pop   (w_q_pop)
    );

    kscip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_vld       (w_q_vld),
        .i_q_item      (w_b_item),
        .o_q_pop       (w_q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_cipher_char (o_cipher_char)
    );

endmodule

>>> hw/rtl/kscip_chk.sv
// ---------------------------------------------------------------------------
// kscip_chk: port-level checks of the cipher
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
module kscip_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [1:0]  i_req_type,
    input logic [7:0]  i_char_in,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_cipher_char
);

    // nothing waits to be read straight after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // queue has room straight after reset
    a_rst_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_cipher_char)))
        else $error("result changed while stalled");

    // a result is zero or an alphabet letter
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_cipher_char == 8'h00)
                    || ((o_cipher_char >= kscip_pkg::CHAR_A)
                        && (o_cipher_char < kscip_pkg::CHAR_A
                                            + 8'(kscip_pkg::ALPHABET_SIZE)))))
        else $error("cipher letter out of range");

endmodule

bind keyword_substitution_cipher kscip_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .i_req_type    (i_req_type),
    .i_char_in     (i_char_in),
    .empty         (empty),
    .pop           (pop),
    .o_cipher_char (o_cipher_char)
);
